// ----- design/ssmp_pkg.sv -----
// Shared constants, codes and controller/datapath types of the sequence store.
package ssmp_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = 7;
    localparam int DATA_W   = 32;
    localparam int ACT_W    = 3;
    localparam int STAT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PURGE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DUMP   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        logic              take_item;
        logic              app_write;
        logic              rd_tail;
        logic              rd_first;
        logic              rd_next;
        logic              purge_step;
        logic              clear;
        logic              emit;
        logic              emit_rdata;
        logic [STAT_W-1:0] emit_status;
        logic              emit_last;
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             full;
        logic             empty;
        logic             at_end;
        logic             out_free;
    } t_stat;

endpackage

// ----- design/ssmp_if.sv -----
// Valid/ready channel interfaces for the input items and the result items.
interface ssmp_in_if;
    import ssmp_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    t_data            value;

    modport source (output valid, action, value, input ready);
    modport sink   (input valid, action, value, output ready);
endinterface

interface ssmp_out_if;
    import ssmp_pkg::*;

    logic              valid;
    logic              ready;
    t_data             data;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
    logic              last;

    modport source (output valid, data, status, count, is_empty, last, input ready);
    modport sink   (input valid, data, status, count, is_empty, last, output ready);
endinterface

// ----- design/sequence_store_with_match_purge.sv -----
// Sequence store: ordered list of signed 32-bit values with append, remove-last,
// purge-equal, clear and dump actions.
//
// One input item (action, value) is taken per transfer on i_in; results leave on
// o_out, each with data, status, count after the action, is_empty and last.
// Every action yields one result, except dump of a non-empty store, which
// yields one result per entry in order, last set on the final one.
// Items are worked one at a time; i_in is ready only in the idle state.
// Append, clear, empty cases and unknown actions load their result from the
// execute state; remove-last loads it from S_REM, since the entry memory has a
// registered read port. Purge walks the store at one entry per cycle through
// that port, then loads its result from S_DONE.
// Dump emits one entry per cycle while o_out is taken.
// A finished result sits in an output register, so i_in accepts the next item
// while that result waits; a stalled receiver holds the purge result or the
// dump walk without loss. Reset empties the store at once (the count returns
// to zero); memory contents need no clearing.
module sequence_store_with_match_purge (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssmp_in_if.sink     i_in,
    ssmp_out_if.source  o_out
);
    import ssmp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ssmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    ssmp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_action    (i_in.action),
        .i_value     (i_in.value),
        .i_out_ready (o_out.ready),
        .o_stat      (stat),
        .o_out_valid (o_out.valid),
        .o_data      (o_out.data),
        .o_status    (o_out.status),
        .o_count     (o_out.count),
        .o_is_empty  (o_out.is_empty),
        .o_last      (o_out.last)
    );

endmodule

// ----- design/ssmp_dp.sv -----
// Datapath: entry memory, fill count, walk indexes and the result register.
module ssmp_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ssmp_pkg::t_cmd                i_cmd,
    input  logic [ssmp_pkg::ACT_W-1:0]    i_action,
    input  ssmp_pkg::t_data               i_value,
    input  logic                          i_out_ready,
    output ssmp_pkg::t_stat               o_stat,
    output logic                          o_out_valid,
    output ssmp_pkg::t_data               o_data,
    output logic [ssmp_pkg::STAT_W-1:0]   o_status,
    output logic [ssmp_pkg::CNT_W-1:0]    o_count,
    output logic                          o_is_empty,
    output logic                          o_last
);
    import ssmp_pkg::*;

    logic [ACT_W-1:0]  r_action;
    t_data             r_value;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  n_fill;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_kept;
    t_data             r_mem [CAPACITY];
    t_data             r_rdata;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_en;
    logic              keep;
    logic              at_end;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_data             wr_data;

    logic              r_out_valid;
    t_data             r_out_data;
    logic [STAT_W-1:0] r_out_status;
    logic [CNT_W-1:0]  r_out_count;
    logic              r_out_is_empty;
    logic              r_out_last;

    assign keep   = (r_rdata != r_value);
    assign at_end = ((CNT_W'(r_idx) + CNT_W'(1)) == r_fill);
    assign rd_en  = i_cmd.rd_tail | i_cmd.rd_first | i_cmd.rd_next;

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.app_write) begin
            n_fill = r_fill + CNT_W'(1);
        end else if (i_cmd.rd_tail) begin
            n_fill = r_fill - CNT_W'(1);
        end else if (i_cmd.clear) begin
            n_fill = '0;
        end else if (i_cmd.purge_step && at_end) begin
            // The survivor count includes the entry compared in this cycle.
            n_fill = r_kept + CNT_W'(keep);
        end
    end

    always_comb begin
        if (i_cmd.rd_tail) begin
            rd_addr = IDX_W'(r_fill - CNT_W'(1));
        end else if (i_cmd.rd_first) begin
            rd_addr = '0;
        end else begin
            rd_addr = r_idx + IDX_W'(1);
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = IDX_W'(r_fill);
        wr_data = r_value;
        if (i_cmd.app_write) begin
            wr_en = 1'b1;
        end else if (i_cmd.purge_step && keep) begin
            // Survivors slide down; the write slot never passes the read slot.
            wr_en   = 1'b1;
            wr_addr = IDX_W'(r_kept);
            wr_data = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
        if (i_cmd.rd_first) begin
            r_idx <= '0;
        end else if (i_cmd.rd_next) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.rd_first) begin
            r_kept <= '0;
        end else if (i_cmd.purge_step && keep) begin
            r_kept <= r_kept + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data     <= i_cmd.emit_rdata ? r_rdata : '0;
            r_out_status   <= i_cmd.emit_status;
            r_out_count    <= n_fill;
            r_out_is_empty <= (n_fill == '0);
            r_out_last     <= i_cmd.emit_last;
        end
    end

    assign o_stat.action   = r_action;
    assign o_stat.full     = (r_fill == CNT_W'(CAPACITY));
    assign o_stat.empty    = (r_fill == '0);
    assign o_stat.at_end   = at_end;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_data      = r_out_data;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;
    assign o_is_empty  = r_out_is_empty;
    assign o_last      = r_out_last;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_kept_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.purge_step |-> (r_kept <= CNT_W'(r_idx)))
        else $error("purge write slot ran ahead of read slot");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.app_write |-> (r_fill < CNT_W'(CAPACITY)))
        else $error("append written into a full store");

    a_tail_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_tail |=> (r_fill == $past(r_fill) - CNT_W'(1)))
        else $error("remove-last did not shrink the store by one");
`endif

endmodule

// ----- design/ssmp_ctrl.sv -----
// Controller: sequences each action as commands to the datapath.
module ssmp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  ssmp_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output ssmp_pkg::t_cmd  o_cmd
);
    import ssmp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_REM   = 3'd2;
    localparam logic [2:0] S_PURGE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;
    localparam logic [2:0] S_DUMP  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state           = r_state;
        o_in_ready        = 1'b0;
        o_cmd             = '0;
        o_cmd.emit_status = ST_OK;
        o_cmd.emit_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                    case (i_stat.action)
                        ACT_APPEND: begin
                            o_cmd.emit = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.emit_status = ST_FULL;
                            end else begin
                                o_cmd.app_write = 1'b1;
                            end
                        end
                        ACT_REMOVE, ACT_PURGE, ACT_DUMP: begin
                            if (i_stat.empty) begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_status = ST_EMPTY;
                            end else if (i_stat.action == ACT_REMOVE) begin
                                o_cmd.rd_tail = 1'b1;
                                n_state       = S_REM;
                            end else if (i_stat.action == ACT_PURGE) begin
                                o_cmd.rd_first = 1'b1;
                                n_state        = S_PURGE;
                            end else begin
                                o_cmd.rd_first = 1'b1;
                                n_state        = S_DUMP;
                            end
                        end
                        ACT_CLEAR: begin
                            o_cmd.emit = 1'b1;
                            if (i_stat.empty) begin
                                o_cmd.emit_status = ST_EMPTY;
                            end else begin
                                o_cmd.clear = 1'b1;
                            end
                        end
                        default: begin
                            o_cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            S_REM: begin
                if (i_stat.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_rdata = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_PURGE: begin
                // One entry compared per cycle while the next one is read.
                o_cmd.purge_step = 1'b1;
                if (i_stat.at_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DUMP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_rdata = 1'b1;
                    o_cmd.emit_last  = i_stat.at_end;
                    if (i_stat.at_end) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- tb/tb_sequence_store_with_match_purge.sv -----
// Self-checking testbench of the sequence store with match purge.
`timescale 1ns / 100ps

module tb_sequence_store_with_match_purge;
    import ssmp_pkg::*;

    typedef struct {
        logic [ACT_W-1:0] action;
        t_data            value;
        bit               wait_drain;
    } t_item;

    typedef struct packed {
        t_data             data;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
        logic              last;
    } t_reply;

    localparam logic [ACT_W-1:0] ACT_TOP = {ACT_W{1'b1}};

    logic i_clk;
    logic i_rst_n;

    ssmp_in_if  in_ch ();
    ssmp_out_if out_ch ();

    sequence_store_with_match_purge dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Local copy of the store contents, updated as each item is taken.
    t_data  store_vals [CAPACITY];
    int     store_cnt = 0;
    t_reply replies_due [$];
    t_item  pending_items [$];
    t_item  cur_item;

    int items_taken = 0;
    int error_cnt = 0;
    int send_gap;
    bit send_burst;
    int recv_stall;
    bit recv_burst;
    int hold_left;
    bit hold_done;

    t_data value_pool [6] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1, 32'sd1,
                              32'sh5A5A_5A5A};

    task automatic flag_error(input string msg);
        error_cnt++;
        if (error_cnt <= 10) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    function automatic void post_reply(input t_data data, input logic [STAT_W-1:0] status,
                                       input logic last);
        t_reply r;
        r.data     = data;
        r.status   = status;
        r.count    = store_cnt[CNT_W-1:0];
        r.is_empty = (store_cnt == 0);
        r.last     = last;
        replies_due.push_back(r);
    endfunction

    // Works out the replies that one taken item causes and updates the store copy.
    function automatic void store_apply(input t_item it);
        int kept;
        case (it.action)
            ACT_APPEND: begin
                if (store_cnt >= CAPACITY) begin
                    post_reply('0, ST_FULL, 1'b1);
                end else begin
                    store_vals[store_cnt] = it.value;
                    store_cnt++;
                    post_reply('0, ST_OK, 1'b1);
                end
            end
            ACT_REMOVE: begin
                if (store_cnt == 0) begin
                    post_reply('0, ST_EMPTY, 1'b1);
                end else begin
                    store_cnt--;
                    post_reply(store_vals[store_cnt], ST_OK, 1'b1);
                end
            end
            ACT_PURGE: begin
                if (store_cnt == 0) begin
                    post_reply('0, ST_EMPTY, 1'b1);
                end else begin
                    kept = 0;
                    for (int i = 0; i < store_cnt; i++) begin
                        if (store_vals[i] != it.value) begin
                            store_vals[kept] = store_vals[i];
                            kept++;
                        end
                    end
                    store_cnt = kept;
                    post_reply('0, ST_OK, 1'b1);
                end
            end
            ACT_CLEAR: begin
                if (store_cnt == 0) begin
                    post_reply('0, ST_EMPTY, 1'b1);
                end else begin
                    store_cnt = 0;
                    post_reply('0, ST_OK, 1'b1);
                end
            end
            ACT_DUMP: begin
                if (store_cnt == 0) begin
                    post_reply('0, ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < store_cnt; i++) begin
                        post_reply(store_vals[i], ST_OK, i == store_cnt - 1);
                    end
                end
            end
            default: post_reply('0, ST_OK, 1'b1);
        endcase
    endfunction

    function automatic void push_item(input logic [ACT_W-1:0] action, input t_data value,
                                      input bit wait_drain = 1'b0);
        t_item it;
        it.action     = action;
        it.value      = value;
        it.wait_drain = wait_drain;
        pending_items.push_back(it);
    endfunction

    function automatic t_data pick_value();
        if ($urandom_range(0, 3) != 0) begin
            return value_pool[$urandom_range(0, 5)];
        end
        return t_data'($urandom);
    endfunction

    function automatic void push_random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            push_item(ACT_APPEND, pick_value());
        end else if (r < 57) begin
            push_item(ACT_REMOVE, t_data'($urandom));
        end else if (r < 69) begin
            push_item(ACT_PURGE, pick_value());
        end else if (r < 81) begin
            push_item(ACT_DUMP, t_data'($urandom));
        end else if (r < 86) begin
            push_item(ACT_CLEAR, t_data'($urandom));
        end else if (r < 92) begin
            push_item(ACT_TOP - ACT_W'($urandom_range(0, 2)), t_data'($urandom));
        end else begin
            push_item(ACT_APPEND, t_data'($urandom));
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("tb_sequence_store_with_match_purge failed");
        $finish;
    end

    // Sender: presents pending items, with a random gap after each transfer.
    always @(posedge i_clk) begin
        bit offer;
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            in_ch.action <= ACT_APPEND;
            in_ch.value  <= '0;
            send_gap     = 0;
            send_burst   = 1'b0;
        end else begin
            offer = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                store_apply(cur_item);
                items_taken++;
                offer    = 1'b0;
                send_gap = send_burst ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 15) == 0) begin
                    send_burst = !send_burst;
                end
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() != 0 &&
                             !(pending_items[0].wait_drain && replies_due.size() != 0)) begin
                    cur_item      = pending_items.pop_front();
                    offer         = 1'b1;
                    in_ch.action <= cur_item.action;
                    in_ch.value  <= cur_item.value;
                end
            end
            in_ch.valid <= offer;
        end
    end

    // One long receiver hold-off while the sender keeps offering items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && items_taken >= 40) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks every result transfer against the oldest expected reply.
    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_stall   = 0;
            recv_burst   = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.data     = out_ch.data;
                got.status   = out_ch.status;
                got.count    = out_ch.count;
                got.is_empty = out_ch.is_empty;
                got.last     = out_ch.last;
                if (replies_due.size() == 0) begin
                    flag_error($sformatf("unexpected result data=%0d status=%0d count=%0d",
                                         got.data, got.status, got.count));
                end else begin
                    want = replies_due.pop_front();
                    if (got !== want) begin
                        flag_error($sformatf({"expected data=%0d status=%0d count=%0d ",
                            "empty=%0b last=%0b, got data=%0d status=%0d count=%0d ",
                            "empty=%0b last=%0b"}, want.data, want.status, want.count,
                            want.is_empty, want.last, got.data, got.status, got.count,
                            got.is_empty, got.last));
                    end
                end
                recv_stall = recv_burst ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 15) == 0) begin
                    recv_burst = !recv_burst;
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
            end
            out_ch.ready <= (recv_stall == 0) && (hold_left == 0);
        end
    end

    initial begin
        i_rst_n = 1'b0;

        // Empty-store cases and unknown actions.
        push_item(ACT_CLEAR, 32'sd7);
        push_item(ACT_REMOVE, -32'sd1);
        push_item(ACT_PURGE, 32'sd0);
        push_item(ACT_DUMP, 32'sh7FFF_FFFF);
        push_item(ACT_DUMP + 3'd1, 32'sh8000_0000);
        push_item(ACT_TOP, -32'sd1);
        // Extreme values, with repeats so that purge removes the head and others.
        push_item(ACT_APPEND, 32'sh8000_0000);
        push_item(ACT_APPEND, 32'sh7FFF_FFFF);
        push_item(ACT_APPEND, 32'sd0);
        push_item(ACT_APPEND, 32'sh8000_0000);
        push_item(ACT_APPEND, -32'sd1);
        push_item(ACT_APPEND, 32'sh7FFF_FFFF);
        push_item(ACT_PURGE, 32'sh8000_0000);
        push_item(ACT_DUMP, 32'sd0);
        push_item(ACT_PURGE, 32'sh7FFF_FFFF);
        push_item(ACT_DUMP, -32'sd1);
        push_item(ACT_PURGE, 32'sd5);
        push_item(ACT_REMOVE, 32'sd0);
        push_item(ACT_DUMP + 3'd2, 32'sd3);
        push_item(ACT_DUMP, 32'sd0);
        push_item(ACT_REMOVE, 32'sd0);
        push_item(ACT_REMOVE, 32'sd0);
        push_item(ACT_APPEND, 32'sd42);
        push_item(ACT_CLEAR, 32'sd0);
        push_item(ACT_CLEAR, 32'sd0);

        // The sender holds this one back until every reply has come.
        push_item(ACT_APPEND, pick_value(), 1'b1);
        for (int i = 0; i < 10; i++) begin
            push_random_item();
        end
        // Fill to capacity and past it, then walk the full store.
        push_item(ACT_CLEAR, t_data'($urandom));
        for (int i = 0; i < CAPACITY + 2; i++) begin
            push_item(ACT_APPEND, pick_value());
        end
        push_item(ACT_DUMP, t_data'($urandom));
        push_item(ACT_PURGE, value_pool[$urandom_range(0, 5)]);
        push_item(ACT_DUMP, t_data'($urandom), 1'b1);
        for (int i = 0; i < 24; i++) begin
            push_random_item();
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_ch.valid) begin
            @(posedge i_clk);
        end
        while (replies_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);

        if (error_cnt == 0 && replies_due.size() == 0) begin
            $display("tb_sequence_store_with_match_purge passed");
        end else begin
            $display("tb_sequence_store_with_match_purge failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ssmp_pkg.sv
design/ssmp_if.sv
design/ssmp_dp.sv
design/ssmp_ctrl.sv
design/sequence_store_with_match_purge.sv
tb/tb_sequence_store_with_match_purge.sv
